// ----- sv/cfe_pkg.sv -----
// Shared types, constants and the CRC-24Q byte update for the frame engine.
package cfe_pkg;

    localparam int CRC_W   = 24;
    localparam int BYTE_W  = 8;
    localparam int MODE_W  = 2;
    localparam int TDATA_W = 40;

    // Low 24 bits of polynomial 0x1864CFB; the x^24 term is implied
    localparam logic [CRC_W-1:0] CRC_POLY = 24'h864CFB;

    localparam logic [MODE_W-1:0] MODE_HASH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SIGN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

    // Kind of result group held in the output queue
    typedef enum logic [1:0] {
        GK_ECHO  = 2'd0,  // one echoed byte, sign mode
        GK_SIGN  = 2'd1,  // last byte echo followed by three CRC bytes
        GK_FRAME = 2'd2   // hash or check frame-end report
    } grp_kind_t;

    typedef struct packed {
        grp_kind_t         kind;
        logic [BYTE_W-1:0] data;
        logic [CRC_W-1:0]  crc;
        logic              ok;
    } grp_t;

    typedef struct packed {
        logic valid;
        grp_t grp;
    } grp_push_t;

    // Advance the CRC by one byte, MSB first, eight shift steps
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic             msb;
        c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++)
        begin
            msb = c[CRC_W-1];
            c   = {c[CRC_W-2:0], 1'b0} ^ (msb ? CRC_POLY : {CRC_W{1'b0}});
        end
        return c;
    endfunction

endpackage

// ----- sv/cfe_core.sv -----
// Frame state: CRC register, check window and mode; turns each request into a result group.
module cfe_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [cfe_pkg::MODE_W-1:0] cfg_data,
    input  logic                       take,
    input  logic [cfe_pkg::BYTE_W-1:0] data_byte,
    input  logic                       last_byte,
    output cfe_pkg::grp_push_t         push
);
    import cfe_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [CRC_W-1:0]  crc_reg,  crc_next;
    logic [BYTE_W-1:0] win_reg [3];
    logic [BYTE_W-1:0] win_next [3];
    logic [1:0]        seen_reg, seen_next;
    logic [CRC_W-1:0]  crc_upd;
    logic              ok;

    // Hold the mode register; writes must arrive only while idle, the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_HASH;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    // Work out the next frame state and the result group for this request
    always_comb
    begin
        crc_upd     = crc_reg;
        seen_next   = seen_reg;
        win_next[0] = win_reg[0];
        win_next[1] = win_reg[1];
        win_next[2] = win_reg[2];
        ok          = 1'b0;
        push.valid  = 1'b0;
        push.grp    = '{kind: GK_FRAME, data: data_byte, crc: '0, ok: 1'b0};

        unique case (mode_reg)
            MODE_SIGN:
            begin
                crc_upd      = crc_feed(crc_reg, data_byte);
                push.valid   = take;
                push.grp.kind = last_byte ? GK_SIGN : GK_ECHO;
                push.grp.crc = crc_upd;
            end
            MODE_CHECK:
            begin
                if (seen_reg == 2'd3)
                begin
                    crc_upd     = crc_feed(crc_reg, win_reg[0]);
                    win_next[0] = win_reg[1];
                    win_next[1] = win_reg[2];
                    win_next[2] = data_byte;
                end
                else
                begin
                    if (seen_reg == 2'd0) win_next[0] = data_byte;
                    if (seen_reg == 2'd1) win_next[1] = data_byte;
                    if (seen_reg == 2'd2) win_next[2] = data_byte;
                    seen_next = seen_reg + 2'd1;
                end
                ok = (seen_next == 2'd3)
                     && (win_next[0] == crc_upd[23:16])
                     && (win_next[1] == crc_upd[15:8])
                     && (win_next[2] == crc_upd[7:0]);
                push.valid    = take && last_byte;
                push.grp.kind = GK_FRAME;
                push.grp.crc  = crc_upd;
                push.grp.ok   = ok;
            end
            default:
            begin
                crc_upd       = crc_feed(crc_reg, data_byte);
                push.valid    = take && last_byte;
                push.grp.kind = GK_FRAME;
                push.grp.crc  = crc_upd;
            end
        endcase

        // Drop the frame state after the closing byte
        crc_next = crc_upd;
        if (last_byte)
        begin
            crc_next    = '0;
            seen_next   = 2'd0;
            win_next[0] = '0;
            win_next[1] = '0;
            win_next[2] = '0;
        end
    end

    // Advance the frame state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= '0;
            seen_reg   <= 2'd0;
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
        end
        else if (take)
        begin
            crc_reg    <= crc_next;
            seen_reg   <= seen_next;
            win_reg[0] <= win_next[0];
            win_reg[1] <= win_next[1];
            win_reg[2] <= win_next[2];
        end
    end

endmodule

// ----- sv/cfe_outq.sv -----
// Two-entry result group queue; plays groups out one result per cycle while m_tready is high.
module cfe_outq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfe_pkg::grp_push_t          push,
    output logic                        space,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cfe_pkg::TDATA_W-1:0] m_tdata,   // out_byte, crc_value, check_ok, last_result
    output logic                        m_tuser,   // is_crc_byte
    output logic                        m_tlast    // frame_end
);
    import cfe_pkg::*;

    grp_t        q_reg [2];
    logic        wr_reg, rd_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  sub_reg;
    grp_t        head;
    logic        grp_done, pop;
    logic [BYTE_W-1:0] out_byte;
    logic [CRC_W-1:0]  crc_value;
    logic              check_ok, last_result;

    assign head     = q_reg[rd_reg];
    assign space    = (cnt_reg != 2'd2);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign grp_done = (head.kind != GK_SIGN) || (sub_reg == 2'd3);
    assign pop      = m_tvalid && m_tready && grp_done;

    // Select the fields of the current result within the head group
    always_comb
    begin
        out_byte    = '0;
        crc_value   = '0;
        check_ok    = 1'b0;
        m_tuser     = 1'b0;
        m_tlast     = 1'b0;
        last_result = 1'b0;
        unique case (head.kind)
            GK_ECHO:
            begin
                out_byte    = head.data;
                last_result = 1'b1;
            end
            GK_SIGN:
            begin
                unique case (sub_reg)
                    2'd0: out_byte = head.data;
                    2'd1: out_byte = head.crc[23:16];
                    2'd2: out_byte = head.crc[15:8];
                    default: out_byte = head.crc[7:0];
                endcase
                if (sub_reg != 2'd0)
                begin
                    m_tuser   = 1'b1;
                    crc_value = head.crc;
                end
                m_tlast     = (sub_reg == 2'd3);
                last_result = (sub_reg == 2'd3);
            end
            default:
            begin
                crc_value   = head.crc;
                check_ok    = head.ok;
                m_tlast     = 1'b1;
                last_result = 1'b1;
            end
        endcase
    end

    assign m_tdata = {6'd0, last_result, check_ok, crc_value, out_byte};

    // Store pushed groups; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            q_reg[wr_reg] <= push.grp;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push.valid && !pop) cnt_next = cnt_reg + 2'd1;
        if (!push.valid && pop) cnt_next = cnt_reg - 2'd1;
    end

    // Advance pointers, fill count and the position within the head group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
            sub_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push.valid) wr_reg <= ~wr_reg;
            if (pop)
            begin
                rd_reg  <= ~rd_reg;
                sub_reg <= 2'd0;
            end
            else if (m_tvalid && m_tready)
            begin
                sub_reg <= sub_reg + 2'd1;
            end
        end
    end

endmodule

// ----- sv/crc24q_frame_engine_top.sv -----
// Top level of the CRC-24Q frame engine: stream ports, frame state and result queue.
// A request's first result is offered in the cycle after it is accepted, if the queue is empty.
// Throughput: one request per cycle while the two-group result queue has space; a sign-mode
// closing byte plays out four results from the queue, which sets the stall.
// Hash and check bytes that do not close a frame make no result and use no queue space.
// Reset (rst_n low, asynchronous): mode returns to hash, CRC, window and queue clear.
module crc24q_frame_engine_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cfe_pkg::MODE_W-1:0]  cfg_data,   // mode
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [cfe_pkg::BYTE_W-1:0]  s_tdata,    // data_byte
    input  logic                        s_tlast,    // last_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cfe_pkg::TDATA_W-1:0] m_tdata,    // out_byte, crc_value, check_ok, last_result
    output logic                        m_tuser,    // is_crc_byte
    output logic                        m_tlast     // frame_end
);
    import cfe_pkg::*;

    grp_push_t push;
    logic      space;
    logic      take;

    assign cfg_ready = 1'b1;
    assign s_tready  = space;
    assign take      = s_tvalid && space;

    // Frame state and result group build
    cfe_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .take      (take),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .push      (push)
    );

    // Result queue and output serialiser
    cfe_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for the CRC-24Q frame engine: predicts every result and checks the output stream.
module tb_top;
    import cfe_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 100;
    localparam int SETTLE       = 4;

    // Low 24 bits of the CRC-24Q polynomial; x^24 is carried in bit 24
    localparam logic [CRC_W-1:0]  POLY_LOW    = 24'h864CFB;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    typedef struct packed {
        logic [BYTE_W-1:0] byte_v;
        logic              crc_flag;
        logic [CRC_W-1:0]  crc;
        logic              ok;
        logic              frame_end;
        logic              last_res;
    } engine_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [MODE_W-1:0]    cfg_data  = MODE_HASH;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    int tx_idle_pct     = 16;
    int rx_idle_pct     = 16;
    int error_count     = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int stall_cycles    = 0;
    int frames_done [4] = '{0, 0, 0, 0};

    // Predicted engine state
    logic [MODE_W-1:0]       pred_mode = MODE_HASH;
    logic [CRC_W-1:0]        pred_crc  = '0;
    logic [2:0][BYTE_W-1:0]  pred_tail = '0;   // entry 0 oldest
    int                      pred_seen = 0;
    engine_result_t          expected_results[$];

    crc24q_frame_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #CLK_HALF clk = ~clk;

    // Advance a CRC-24Q value by one byte, MSB first
    function automatic logic [CRC_W-1:0] crc24_next(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W:0] acc;
        acc = {1'b0, crc ^ {b, 16'h0000}};
        for (int i = 0; i < BYTE_W; i++)
        begin
            acc = acc << 1;
            if (acc[CRC_W])
                acc = acc ^ {1'b1, POLY_LOW};
        end
        return acc[CRC_W-1:0];
    endfunction

    task automatic clear_frame_state();
        frames_done[pred_mode]++;
        pred_crc  = '0;
        pred_tail = '0;
        pred_seen = 0;
    endtask

    // Work out the results of one accepted request and queue them
    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic ok;
        if (pred_mode == MODE_SIGN)
        begin
            pred_crc = crc24_next(pred_crc, b);
            expected_results.push_back('{b, 1'b0, 24'h0, 1'b0, 1'b0, !last});
            if (last)
            begin
                expected_results.push_back('{pred_crc[23:16], 1'b1, pred_crc, 1'b0, 1'b0, 1'b0});
                expected_results.push_back('{pred_crc[15:8], 1'b1, pred_crc, 1'b0, 1'b0, 1'b0});
                expected_results.push_back('{pred_crc[7:0], 1'b1, pred_crc, 1'b0, 1'b1, 1'b1});
                clear_frame_state();
            end
        end
        else if (pred_mode == MODE_CHECK)
        begin
            // Hold back the newest three bytes; feed the one pushed out
            if (pred_seen == 3)
            begin
                pred_crc  = crc24_next(pred_crc, pred_tail[0]);
                pred_tail = {b, pred_tail[2:1]};
            end
            else
            begin
                pred_tail[pred_seen] = b;
                pred_seen++;
            end
            if (last)
            begin
                ok = (pred_seen == 3) &&
                     (pred_tail == {pred_crc[7:0], pred_crc[15:8], pred_crc[23:16]});
                expected_results.push_back('{8'h00, 1'b0, pred_crc, ok, 1'b1, 1'b1});
                clear_frame_state();
            end
        end
        else
        begin
            // Hash, and the unused mode value behaves the same
            pred_crc = crc24_next(pred_crc, b);
            if (last)
            begin
                expected_results.push_back('{8'h00, 1'b0, pred_crc, 1'b0, 1'b1, 1'b1});
                clear_frame_state();
            end
        end
    endtask

    // Offer one request after a random gap and hold it until accepted
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_byte(b, last);
        items_sent++;
    endtask

    task automatic send_frame(input byte_q_t bytes);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Drop valid and wait until every queued result has come out, then settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] m);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        pred_mode = m;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_hash();
        set_mode(MODE_HASH);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_unused_mode();
        set_mode(MODE_UNUSED);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_sign();
        set_mode(MODE_SIGN);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_check();
        logic [CRC_W-1:0] c;
        set_mode(MODE_CHECK);
        // Frames too short to carry a CRC
        send_byte(8'hA5, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b1);
        // Empty body with a zero CRC trailer
        send_frame('{8'h00, 8'h00, 8'h00});
        // One body byte followed by its CRC, high byte first
        c = crc24_next('0, 8'hC3);
        send_frame('{8'hC3, c[23:16], c[15:8], c[7:0]});
    endtask

    // Mode written between bytes of one frame; the frame state carries over
    task automatic test_mid_frame_switch();
        set_mode(MODE_HASH);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        set_mode(MODE_SIGN);
        send_byte(8'h56, 1'b1);
        set_mode(MODE_CHECK);
        send_byte(8'h78, 1'b0);
        send_byte(8'h9A, 1'b0);
        set_mode(MODE_HASH);
        send_byte(8'hBC, 1'b1);
    endtask

    task automatic test_random();
        byte_q_t          frame;
        logic [CRC_W-1:0] c;
        logic [BYTE_W-1:0] b;
        int               start;
        int               frame_no;
        int               len;
        int               pick;
        int               pos;
        start    = items_sent;
        frame_no = 0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            // Hold a stretch of frames with no idling on either side
            if (frame_no >= 8 && frame_no < 14)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = 16;
                rx_idle_pct = 16;
            end
            if (frame_no == 20)
                wait_drained();
            if (frame_no == 0 || $urandom_range(2) == 0)
            begin
                pick = $urandom_range(9);
                if (pick < 3)
                    set_mode(MODE_HASH);
                else if (pick < 6)
                    set_mode(MODE_SIGN);
                else if (pick < 9)
                    set_mode(MODE_CHECK);
                else
                    set_mode(MODE_UNUSED);
            end
            len = ($urandom_range(7) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
            frame.delete();
            if (pred_mode == MODE_CHECK && $urandom_range(3) != 0)
            begin
                // Well-formed check frame: body then its CRC
                c = '0;
                for (int i = 0; i < len - 1; i++)
                begin
                    b = BYTE_W'($urandom_range(255));
                    frame.push_back(b);
                    c = crc24_next(c, b);
                end
                frame.push_back(c[23:16]);
                frame.push_back(c[15:8]);
                frame.push_back(c[7:0]);
                // Now and then corrupt one trailer bit
                if ($urandom_range(4) == 0)
                begin
                    pos = frame.size() - 1 - $urandom_range(2);
                    frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(7));
                end
            end
            else
            begin
                for (int i = 0; i < len; i++)
                    frame.push_back(BYTE_W'($urandom_range(255)));
            end
            send_frame(frame);
            frame_no++;
        end
    endtask

    // Drive ready with random stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    function automatic void compare_field(input string name, input logic [CRC_W-1:0] want,
                                          input logic [CRC_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: result %0d mismatch on %s: expected %0h, actual %0h",
                     $time, results_checked, name, want, got);
            error_count++;
        end
    endfunction

    // Compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        engine_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, %s %0h tuser %0b tlast %0b",
                         $time, "actual tdata", m_tdata, m_tuser, m_tlast);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("out_byte", want.byte_v, m_tdata[7:0]);
                compare_field("crc_value", want.crc, m_tdata[31:8]);
                compare_field("check_ok", want.ok, m_tdata[32]);
                compare_field("last_result", want.last_res, m_tdata[33]);
                compare_field("tdata padding", '0, m_tdata[TDATA_W-1:34]);
                compare_field("is_crc_byte", want.crc_flag, m_tuser);
                compare_field("frame_end", want.frame_end, m_tlast);
                results_checked++;
            end
        end
    end

    // End the run if no request moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, expected_results.size());
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_hash();
        test_unused_mode();
        test_sign();
        test_check();
        test_mid_frame_switch();
        test_random();
        wait_drained();
        repeat (16) @(posedge clk);
        $display("Sent %0d bytes: %0d hash, %0d sign, %0d check, %0d mode-three frame ends.",
                 items_sent, frames_done[MODE_HASH], frames_done[MODE_SIGN],
                 frames_done[MODE_CHECK], frames_done[MODE_UNUSED]);
        $display("Checked %0d results with %0d mismatches.", results_checked, error_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
